### hdl/lsre_pkg.sv
package lsre_pkg;

  // Label store geometry
  localparam int LabelMax = 40;
  localparam int AddrW    = $clog2(LabelMax);
  // Label length saturates at LabelMax+1 to flag an overlong literal
  localparam int LenW     = $clog2(LabelMax + 2);

  localparam int ByteW  = 8;
  localparam int RunW   = 8;
  localparam int DepthW = 16;

  localparam logic [DepthW-1:0] DepthMax     = '1;
  localparam logic [RunW-1:0]   MaxRunsReset = 8'd16;

  // Characters of interest
  localparam logic [ByteW-1:0] CharOpen   = 8'h28;
  localparam logic [ByteW-1:0] CharClose  = 8'h29;
  localparam logic [ByteW-1:0] CharBslash = 8'h5C;
  localparam logic [ByteW-1:0] CharDot    = 8'h2E;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;

  // Write request into the label store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } mem_wr_t;

  // Label readout request from parser to emitter
  typedef struct packed {
    logic            start;
    logic [LenW-1:0] n;
    logic [LenW-1:0] keep;
    logic [RunW-1:0] run;
  } emit_req_t;

  typedef enum logic {
    EmitIdle,
    EmitRead
  } emit_state_e;

endpackage

### hdl/literal_string_run_extractor.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  content_byte_i, stream_last_i, page_first_i
// output    out        out_valid_o/out_ready_i label_byte_o, label_last_o, run_number_o
// config    in         cfg_we_i (no wait)     cfg_wdata_i (max_runs)
//
// Content bytes are taken one per cycle while no label is being read out.
// A closing ')' of a non-empty literal holds the input off for the readout:
// the single label store read port has a registered read and one read in
// flight, so each label byte is read only after the previous one has moved
// to the output register; output stalls lengthen the readout.
// The last label byte may wait in the output register while scanning resumes.
// Reset sets max_runs to 16 and clears depth, escape, length and run count;
// the label store is not cleared and needs no clearing pass.
module literal_string_run_extractor
  import lsre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RunW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] content_byte_i,
  input  logic             stream_last_i,
  input  logic             page_first_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] label_byte_o,
  output logic             label_last_o,
  output logic [RunW-1:0]  run_number_o
);

  mem_wr_t          wr;
  emit_req_t        req;
  logic             busy;
  logic             accept;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [ByteW-1:0] rdata;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  lsre_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .content_byte_i (content_byte_i),
    .stream_last_i  (stream_last_i),
    .page_first_i   (page_first_i),
    .wr_o           (wr),
    .req_o          (req)
  );

  lsre_label_ram #(
    .Depth (LabelMax),
    .Width (ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lsre_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .busy_o       (busy),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .label_byte_o (label_byte_o),
    .label_last_o (label_last_o),
    .run_number_o (run_number_o)
  );

  // Store is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr.we && re))
    else $error("label store write and read collide");

  // Readout request only from an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) req.start |-> accept)
    else $error("label readout without accepted byte");

  // A readout leaves the input held off for at least its first read
  assert property (@(posedge clk_i) disable iff (!rst_ni) req.start |=> !in_ready_o)
    else $error("input not held off at start of readout");

  // While a non-final label byte is shown the readout is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !label_last_o) |-> !in_ready_o)
    else $error("input taken in the middle of a label");

  // Emitted bytes are never control bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (label_byte_o >= CharSpace))
    else $error("control byte on label output");

endmodule

### hdl/lsre_label_ram.sv
module lsre_label_ram #(
  parameter int Depth = 40,
  parameter int Width = 8,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lsre_parser.sv
module lsre_parser
  import lsre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RunW-1:0]  cfg_wdata_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] content_byte_i,
  input  logic             stream_last_i,
  input  logic             page_first_i,
  output mem_wr_t          wr_o,
  output emit_req_t        req_o
);

  logic [RunW-1:0]   max_runs_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              esc_q, esc_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [RunW-1:0]   runs_q, runs_d;
  logic              append;

  // Scan one content byte
  always_comb begin
    depth_d = depth_q;
    esc_d   = esc_q;
    len_d   = len_q;
    runs_d  = runs_q;
    append  = 1'b0;
    wr_o    = '0;
    req_o   = '0;
    if (accept_i) begin
      if (page_first_i) begin
        runs_d  = '0;
        depth_d = '0;
        esc_d   = 1'b0;
        len_d   = '0;
      end
      if (runs_d < max_runs_q) begin
        if (depth_d == '0) begin
          if (content_byte_i == CharOpen) begin
            depth_d = DepthW'(1);
            len_d   = '0;
            esc_d   = 1'b0;
          end
        end else if (esc_d) begin
          esc_d  = 1'b0;
          append = 1'b1;
        end else if (content_byte_i == CharBslash && !stream_last_i) begin
          esc_d = 1'b1;
        end else if (content_byte_i == CharOpen) begin
          if (depth_d != DepthMax) begin
            depth_d = depth_d + DepthW'(1);
          end
          append = 1'b1;
        end else if (content_byte_i == CharClose) begin
          depth_d = depth_d - DepthW'(1);
          if (depth_d == '0) begin
            // outermost close: hand a non-empty label to the emitter
            if (len_d != '0) begin
              req_o.start = 1'b1;
              req_o.n     = (len_d > LenW'(LabelMax)) ? LenW'(LabelMax) : len_d;
              req_o.keep  = (len_d > LenW'(LabelMax)) ? LenW'(LabelMax - 2) : len_d;
              req_o.run   = runs_d;
              runs_d      = runs_d + RunW'(1);
            end
            len_d = '0;
          end else begin
            append = 1'b1;
          end
        end else begin
          append = 1'b1;
        end
      end
      // store byte; length saturates one past the store size
      if (append) begin
        if (len_d < LenW'(LabelMax)) begin
          wr_o.we   = 1'b1;
          wr_o.addr = len_d[AddrW-1:0];
          wr_o.data = content_byte_i;
        end
        if (len_d < LenW'(LabelMax + 1)) begin
          len_d = len_d + LenW'(1);
        end
      end
      if (stream_last_i) begin
        depth_d = '0;
        esc_d   = 1'b0;
        len_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_runs_q <= MaxRunsReset;
      depth_q    <= '0;
      esc_q      <= 1'b0;
      len_q      <= '0;
      runs_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_runs_q <= cfg_wdata_i;
      end
      depth_q <= depth_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      runs_q  <= runs_d;
    end
  end

endmodule

### hdl/lsre_emitter.sv
module lsre_emitter
  import lsre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emit_req_t        req_i,
  output logic             busy_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  input  logic [ByteW-1:0] rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] label_byte_o,
  output logic             label_last_o,
  output logic [RunW-1:0]  run_number_o
);

  emit_state_e      state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [LenW-1:0]  n_q, keep_q;
  logic [RunW-1:0]  run_q;
  logic             issue, is_last;
  logic             pend_q, pend_last_q, pend_dot_q;
  logic             out_valid_q, out_last_q;
  logic [ByteW-1:0] out_byte_q, byte_fix;
  logic [RunW-1:0]  out_run_q;

  // One read in flight; issue only when the output register is free next cycle
  assign issue   = (state_q == EmitRead) && !pend_q && (!out_valid_q || out_ready_i);
  assign is_last = (LenW'(idx_q) == n_q - LenW'(1));
  assign re_o    = issue;
  assign raddr_o = idx_q;
  assign busy_o  = (state_q == EmitRead);

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      EmitIdle: begin
        if (req_i.start) begin
          state_d = EmitRead;
          idx_d   = '0;
        end
      end
      EmitRead: begin
        if (issue) begin
          if (is_last) begin
            state_d = EmitIdle;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end
      default: state_d = EmitIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EmitIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Label geometry and per-read flags
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (req_i.start && state_q == EmitIdle) begin
      n_q    <= req_i.n;
      keep_q <= req_i.keep;
      run_q  <= req_i.run;
    end
    if (issue) begin
      pend_last_q <= is_last;
      pend_dot_q  <= (LenW'(idx_q) >= keep_q);
    end
  end

  // Truncation dots and control bytes shown as space
  always_comb begin
    if (pend_dot_q) begin
      byte_fix = CharDot;
    end else if (rdata_i < CharSpace) begin
      byte_fix = CharSpace;
    end else begin
      byte_fix = rdata_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_byte_q <= byte_fix;
      out_last_q <= pend_last_q;
      out_run_q  <= run_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign label_byte_o = out_byte_q;
  assign label_last_o = out_last_q;
  assign run_number_o = out_run_q;

endmodule
